/* hdl/tpsr_pkg.sv */
package tpsr_pkg;

  // Fixed field widths of a detection.
  localparam int VIDEO_W = 8;
  localparam int FRAME_W = 24;

  // Configuration register widths.
  localparam int TOL_W = 7;
  localparam int GAP_W = 10;

  // Configuration write channel widths.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;

  // Register indexes on the configuration channel.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TOLERANCE = 2'd0,
    CFG_MAX_GAP   = 2'd1
  } cfg_index_t;

  // Register reset values.
  localparam logic [TOL_W-1:0] TOL_RESET = 7'd20;
  localparam logic [GAP_W-1:0] GAP_RESET = 10'd30;

  // Scale of the percent band.
  localparam int PERCENT_SCALE = 100;

endpackage

/* hdl/tpsr_det_if.sv */
interface tpsr_det_if #(
  parameter int COORD_WIDTH = 13
);
  logic                         valid;
  logic                         ready;
  logic [tpsr_pkg::VIDEO_W-1:0] video_index;
  logic [tpsr_pkg::FRAME_W-1:0] frame_number;
  logic [COORD_WIDTH-1:0]       x_position;
  logic [COORD_WIDTH-1:0]       y_position;
  logic                         end_of_list;

  modport source (
    output valid, video_index, frame_number, x_position, y_position, end_of_list,
    input  ready
  );
  modport sink (
    input  valid, video_index, frame_number, x_position, y_position, end_of_list,
    output ready
  );
endinterface

/* hdl/tpsr_res_if.sv */
interface tpsr_res_if #(
  parameter int COORD_WIDTH = 13
);
  logic                         valid;
  logic                         ready;
  logic [tpsr_pkg::VIDEO_W-1:0] out_video_index;
  logic [tpsr_pkg::FRAME_W-1:0] out_frame_number;
  logic [COORD_WIDTH-1:0]       out_x;
  logic [COORD_WIDTH-1:0]       out_y;
  logic                         drop;
  logic                         last_out;

  modport source (
    output valid, out_video_index, out_frame_number, out_x, out_y, drop, last_out,
    input  ready
  );
  modport sink (
    input  valid, out_video_index, out_frame_number, out_x, out_y, drop, last_out,
    output ready
  );
endinterface

/* hdl/tpsr_cfg_if.sv */
interface tpsr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tpsr_pkg::CFG_INDEX_W-1:0] index;
  logic [tpsr_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/three_point_spike_rejector.sv */
// Channel   | Direction | Beat contents
// ----------+-----------+------------------------------------------------------
// in_ch     | sink      | video_index, frame_number, x/y_position, end_of_list
// out_ch    | source    | out_video_index, out_frame_number, out_x, out_y,
//           |           | drop, last_out
// cfg_ch    | sink      | index, data (register write, always ready)
//
// One input beat is taken per cycle while in_ch.ready is high; its verdict is
// formed in the same cycle from the two held window items and written into a
// four-entry result queue. A beat yields zero, one or two results; the queue's
// single read port sets the output rate at one result per cycle unless stalled.
// in_ch.ready is high while the queue holds two results or fewer.
// Reset (rst_n low, synchronous) empties the window and the queue and loads
// the register defaults; out_ch.valid is low the cycle after reset.
module three_point_spike_rejector #(
  parameter int COORD_WIDTH = 13
) (
  input  logic       clk,
  input  logic       rst_n,
  tpsr_det_if.sink   in_ch,
  tpsr_res_if.source out_ch,
  tpsr_cfg_if.sink   cfg_ch
);

  localparam int ARITH_W     = COORD_WIDTH + 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [tpsr_pkg::VIDEO_W-1:0] vid;
    logic [tpsr_pkg::FRAME_W-1:0] frame;
    logic [COORD_WIDTH-1:0]       x;
    logic [COORD_WIDTH-1:0]       y;
  } det_t;

  typedef struct packed {
    det_t det;
    logic drop;
    logic last;
  } res_t;

  // Registers.
  logic [tpsr_pkg::TOL_W-1:0] tol_r;
  logic [tpsr_pkg::GAP_W-1:0] gap_r;
  det_t                       older_r, older_nxt;
  det_t                       newer_r, newer_nxt;
  logic [1:0]                 held_r, held_nxt;
  logic                       skip_r, skip_nxt;
  res_t                       queue_r [QUEUE_DEPTH];
  res_t                       queue_nxt [QUEUE_DEPTH];
  logic [QCNT_W-1:0]          count_r, count_nxt;

  // Step signals.
  det_t              cur;
  logic              accept;
  logic              pop;
  logic              judged;
  logic              gap_ok;
  logic [tpsr_pkg::FRAME_W:0] delta;
  res_t              res0;
  res_t              res1;
  logic [1:0]        push_n;
  logic [QCNT_W-1:0] base;

  // One axis: neighbours close together, middle value outside the band.
  function automatic logic axis_spike(
    input logic [COORD_WIDTH-1:0]     a,
    input logic [COORD_WIDTH-1:0]     b,
    input logic [COORD_WIDTH-1:0]     c,
    input logic [tpsr_pkg::TOL_W-1:0] tol
  );
    logic [COORD_WIDTH-1:0] diff_ac;
    logic [ARITH_W-1:0]     sum;
    logic [ARITH_W-1:0]     band;
    logic [ARITH_W-1:0]     twice_b;
    logic [ARITH_W-1:0]     dev;
    logic                   stable;
    logic                   outlier;
    diff_ac = (a > c) ? a - c : c - a;
    sum     = ARITH_W'(a) + ARITH_W'(c);
    band    = ARITH_W'(tol) * sum;
    twice_b = ARITH_W'(b) << 1;
    dev     = (twice_b > sum) ? twice_b - sum : sum - twice_b;
    stable  = (ARITH_W'(diff_ac) * ARITH_W'(tpsr_pkg::PERCENT_SCALE)) < band;
    outlier = (dev * ARITH_W'(tpsr_pkg::PERCENT_SCALE)) > band;
    return stable && outlier;
  endfunction

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (count_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign accept       = in_ch.valid && in_ch.ready;

  assign out_ch.valid            = (count_r != '0);
  assign pop                     = out_ch.valid && out_ch.ready;
  assign out_ch.out_video_index  = queue_r[0].det.vid;
  assign out_ch.out_frame_number = queue_r[0].det.frame;
  assign out_ch.out_x            = queue_r[0].det.x;
  assign out_ch.out_y            = queue_r[0].det.y;
  assign out_ch.drop             = queue_r[0].drop;
  assign out_ch.last_out         = queue_r[0].last;

  assign cur.vid   = in_ch.video_index;
  assign cur.frame = in_ch.frame_number;
  assign cur.x     = in_ch.x_position;
  assign cur.y     = in_ch.y_position;

  // Neighbour test: same video, later minus earlier frame below max_gap.
  // A negative difference always passes.
  assign delta  = {1'b0, cur.frame} - {1'b0, older_r.frame};
  assign gap_ok = delta[tpsr_pkg::FRAME_W] ||
                  (delta[tpsr_pkg::FRAME_W-1:0] < tpsr_pkg::FRAME_W'(gap_r));
  assign judged = (held_r == 2'd2) && !skip_r &&
                  (older_r.vid == cur.vid) && gap_ok &&
                  axis_spike(older_r.x, newer_r.x, cur.x, tol_r) &&
                  axis_spike(older_r.y, newer_r.y, cur.y, tol_r);

  // Window update and the results of one beat.
  always_comb begin
    older_nxt = older_r;
    newer_nxt = newer_r;
    held_nxt  = held_r;
    skip_nxt  = skip_r;
    res0      = '{det: cur, drop: 1'b0, last: 1'b1};
    res1      = '{det: cur, drop: 1'b0, last: 1'b1};
    push_n    = 2'd0;
    if (accept) begin
      if (held_r == 2'd0) begin
        if (!in_ch.end_of_list) begin
          newer_nxt = cur;
          held_nxt  = 2'd1;
          skip_nxt  = 1'b0;
        end else begin
          push_n = 2'd1;
        end
      end else begin
        res0      = '{det: newer_r, drop: judged, last: 1'b0};
        push_n    = in_ch.end_of_list ? 2'd2 : 2'd1;
        older_nxt = newer_r;
        newer_nxt = cur;
        held_nxt  = 2'd2;
        skip_nxt  = judged;
      end
      if (in_ch.end_of_list) begin
        held_nxt = 2'd0;
        skip_nxt = 1'b0;
      end
    end
  end

  // Result queue: head at entry zero, new results land after the survivors.
  always_comb begin
    base = count_r - QCNT_W'(pop);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      queue_nxt[i] = queue_r[i];
    end
    if (pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        queue_nxt[i] = queue_r[i + 1];
      end
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if ((push_n != 2'd0) && (QCNT_W'(i) == base)) begin
        queue_nxt[i] = res0;
      end else if ((push_n == 2'd2) && (QCNT_W'(i) == base + QCNT_W'(1))) begin
        queue_nxt[i] = res1;
      end
    end
    count_nxt = base + QCNT_W'(push_n);
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= tpsr_pkg::TOL_RESET;
      gap_r   <= tpsr_pkg::GAP_RESET;
      held_r  <= 2'd0;
      skip_r  <= 1'b0;
      count_r <= '0;
    end else begin
      held_r  <= held_nxt;
      skip_r  <= skip_nxt;
      count_r <= count_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          tpsr_pkg::CFG_TOLERANCE: tol_r <= cfg_ch.data[tpsr_pkg::TOL_W-1:0];
          tpsr_pkg::CFG_MAX_GAP:   gap_r <= cfg_ch.data[tpsr_pkg::GAP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    older_r <= older_nxt;
    newer_r <= newer_nxt;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      queue_r[i] <= queue_nxt[i];
    end
  end

endmodule

/* hdl/tpsr_checker.sv */
module tpsr_checker #(
  parameter int COORD_WIDTH = 13
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tpsr_pkg::VIDEO_W-1:0] out_video_index,
  input logic [tpsr_pkg::FRAME_W-1:0] out_frame_number,
  input logic [COORD_WIDTH-1:0]       out_x,
  input logic [COORD_WIDTH-1:0]       out_y,
  input logic                         drop,
  input logic                         last_out
);

  logic out_beat;
  logic prev_drop_r;
  logic at_start_r;

  assign out_beat = out_valid && out_ready;

  // Track the verdict of the previous result beat and the start of a stream.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_drop_r <= 1'b0;
      at_start_r  <= 1'b1;
    end else if (out_beat) begin
      prev_drop_r <= drop;
      at_start_r  <= last_out;
    end
  end

  // The final result of a stream is always kept.
  a_last_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_out |-> !drop)
    else $error("last result marked for deletion");

  // A result that follows a dropped one is never dropped.
  a_no_double_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && prev_drop_r |-> !drop)
    else $error("two dropped results in a row");

  // The first result of a stream is always kept.
  a_first_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && at_start_r |-> !drop)
    else $error("first result of a stream marked for deletion");

  // No result is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // A stalled result beat holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_video_index) &&
      $stable(out_frame_number) && $stable(out_x) && $stable(out_y) &&
      $stable(drop) && $stable(last_out))
    else $error("stalled result beat changed");

endmodule

bind three_point_spike_rejector tpsr_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_tpsr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_video_index (out_ch.out_video_index),
  .out_frame_number(out_ch.out_frame_number),
  .out_x           (out_ch.out_x),
  .out_y           (out_ch.out_y),
  .drop            (out_ch.drop),
  .last_out        (out_ch.last_out)
);

/* verif/three_point_spike_rejector_tb.sv */
`timescale 1ns / 100ps

module three_point_spike_rejector_tb;

  localparam int CW           = 13;
  localparam int COORD_MAX    = (1 << CW) - 1;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_ITEMS  = 250;
  localparam int MAX_REPORTS  = 10;
  localparam int SETTLE_TICKS = 4;

  // Field and register widths shared with the block.
  localparam int VIDEO_W     = tpsr_pkg::VIDEO_W;
  localparam int FRAME_W     = tpsr_pkg::FRAME_W;
  localparam int TOL_W       = tpsr_pkg::TOL_W;
  localparam int GAP_W       = tpsr_pkg::GAP_W;
  localparam int CFG_INDEX_W = tpsr_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W  = tpsr_pkg::CFG_DATA_W;

  // Register indexes past the end of the list; writes to them must be ignored.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [VIDEO_W-1:0] video;
    logic [FRAME_W-1:0] frame;
    logic [CW-1:0]      x;
    logic [CW-1:0]      y;
  } det_t;

  typedef struct {
    det_t det;
    bit   drop;
    bit   is_last;
  } verdict_t;

  logic clk;
  logic rst_n;

  tpsr_det_if #(.COORD_WIDTH(CW)) in_bus ();
  tpsr_res_if #(.COORD_WIDTH(CW)) out_bus ();
  tpsr_cfg_if                     cfg_bus ();

  three_point_spike_rejector #(.COORD_WIDTH(CW)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // Shadow of the block's registers and detection window.
  logic [TOL_W-1:0] tol_pct         = tpsr_pkg::TOL_RESET;
  logic [GAP_W-1:0] gap_limit       = tpsr_pkg::GAP_RESET;
  det_t             win_older       = '0;
  det_t             win_newer       = '0;
  int               held_n          = 0;
  bit               skip_after_drop = 1'b0;

  verdict_t pending_verdicts[$];

  int error_count  = 0;
  int items_sent   = 0;
  int cycle_count  = 0;
  int src_idle_max = 15;
  int snk_idle_max = 15;
  int hold_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void note_failure(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("ERROR cycle %0d: %s", cycle_count, msg);
    end
  endfunction

  function automatic longint abs_val(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Append one expected result at the tail of the scoreboard.
  function automatic void queue_verdict(input det_t d, input bit drop, input bit is_last);
    verdict_t v;
    v.det     = d;
    v.drop    = drop;
    v.is_last = is_last;
    pending_verdicts.insert(pending_verdicts.size(), v);
  endfunction

  // One axis: the neighbors agree within the band and the middle lies outside it.
  function automatic bit axis_spike(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                    input logic [CW-1:0] c);
    longint sum;
    longint band;
    sum  = longint'(a) + longint'(c);
    band = longint'(tol_pct) * sum;
    return (tpsr_pkg::PERCENT_SCALE * abs_val(longint'(a) - longint'(c)) < band) &&
           (tpsr_pkg::PERCENT_SCALE * abs_val(2 * longint'(b) - sum) > band);
  endfunction

  // Verdict on the middle detection given both neighbors.
  function automatic bit is_spike(input det_t older, input det_t middle, input det_t newest);
    longint delta;
    if (older.video != newest.video) return 1'b0;
    delta = longint'(newest.frame) - longint'(older.frame);
    if (!(delta < longint'(gap_limit))) return 1'b0;
    return axis_spike(older.x, middle.x, newest.x) && axis_spike(older.y, middle.y, newest.y);
  endfunction

  // Advance the window by one accepted detection and queue the verdicts it releases.
  function automatic void predict_verdicts(input det_t d, input bit is_last);
    bit drop;
    if (held_n == 1) begin
      queue_verdict(win_newer, 1'b0, 1'b0);
      win_older       = win_newer;
      win_newer       = d;
      held_n          = 2;
      skip_after_drop = 1'b0;
    end else if (held_n == 2) begin
      drop = skip_after_drop ? 1'b0 : is_spike(win_older, win_newer, d);
      queue_verdict(win_newer, drop, 1'b0);
      skip_after_drop = drop;
      win_older       = win_newer;
      win_newer       = d;
    end else if (!is_last) begin
      win_newer       = d;
      held_n          = 1;
      skip_after_drop = 1'b0;
    end
    if (is_last) begin
      queue_verdict(d, 1'b0, 1'b1);
      held_n          = 0;
      skip_after_drop = 1'b0;
    end
  endfunction

  function automatic void apply_register(input logic [CFG_INDEX_W-1:0] index,
                                         input logic [CFG_DATA_W-1:0] data);
    case (index)
      tpsr_pkg::CFG_TOLERANCE: tol_pct = data[TOL_W-1:0];
      tpsr_pkg::CFG_MAX_GAP:   gap_limit = data[GAP_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic det_t mk_det(input int video, input int frame, input int x, input int y);
    det_t d;
    d.video = VIDEO_W'(video);
    d.frame = FRAME_W'(frame);
    d.x     = CW'(x);
    d.y     = CW'(y);
    return d;
  endfunction

  // Small random deviation around a track position, kept inside the coordinate range.
  function automatic int wobble(input int base, input int spread);
    int v;
    v = base + int'($urandom_range(2 * spread, 0)) - spread;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  // A jump far away from the track in either direction.
  function automatic int spike_of(input int base);
    return (base < COORD_MAX / 3) ? base * 3 : base / 4;
  endfunction

  // Offer one detection beat after a random gap and wait for it to be taken.
  task automatic send_det(input det_t d, input bit is_last);
    int gap_cycles;
    gap_cycles = $urandom_range(src_idle_max, 0);
    if (gap_cycles > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap_cycles) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.video_index  <= d.video;
    in_bus.frame_number <= d.frame;
    in_bus.x_position   <= d.x;
    in_bus.y_position   <= d.y;
    in_bus.end_of_list  <= is_last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predict_verdicts(d, is_last);
    items_sent++;
  endtask

  // Register write beat; valid drops for a cycle so back-to-back writes stay clean.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    apply_register(index, data);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Park the sender and let every expected verdict drain out of the block.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // A mostly smooth ball track with spikes, video switches, frame jumps and noise.
  task automatic send_track_stream(input int n_items);
    det_t               d;
    logic [VIDEO_W-1:0] vid;
    logic [FRAME_W-1:0] frame;
    int                 bx;
    int                 by;
    int                 roll;
    int                 i;
    vid   = VIDEO_W'($urandom);
    frame = FRAME_W'($urandom);
    bx    = $urandom_range(COORD_MAX, 16);
    by    = $urandom_range(COORD_MAX, 16);
    for (i = 0; i < n_items; i++) begin
      roll    = $urandom_range(99, 0);
      frame   = frame + FRAME_W'($urandom_range(3, 1));
      d.video = vid;
      d.frame = frame;
      d.x     = CW'(wobble(bx, bx * int'(tol_pct) / 400));
      d.y     = CW'(wobble(by, by * int'(tol_pct) / 400));
      if (roll < 22) begin
        d.x = CW'(spike_of(bx));
        d.y = CW'(spike_of(by));
      end else if (roll < 28) begin
        d.video = VIDEO_W'($urandom);
        d.frame = FRAME_W'($urandom);
        d.x     = CW'($urandom);
        d.y     = CW'($urandom);
      end else if (roll < 31) begin
        vid     = vid + VIDEO_W'(1);
        d.video = vid;
      end else if (roll < 34) begin
        frame   = frame + FRAME_W'($urandom_range(2000, 20));
        d.frame = frame;
      end else if (roll < 36) begin
        frame   = frame - FRAME_W'($urandom_range(50, 1));
        d.frame = frame;
      end else if (roll < 38) begin
        bx = $urandom_range(COORD_MAX, 16);
        by = $urandom_range(COORD_MAX, 16);
      end
      send_det(d, i == n_items - 1);
    end
  endtask

  // Reset defaults: stream edges, spikes with the skip rule, neighbor conditions.
  task automatic test_directed_defaults();
    send_det(mk_det(3, 100, 500, 500), 1'b1);
    send_det(mk_det(3, 200, 500, 500), 1'b0);
    send_det(mk_det(3, 201, 600, 600), 1'b1);
    // Alternating spikes: the second item is dropped; the third would be dropped if it were judged.
    send_det(mk_det(255, 'hFFFFF0, 1000, 2000), 1'b0);
    send_det(mk_det(255, 'hFFFFF1, 3000, 6000), 1'b0);
    send_det(mk_det(255, 'hFFFFF2, 1000, 2000), 1'b0);
    send_det(mk_det(255, 'hFFFFF3, 3000, 6000), 1'b0);
    send_det(mk_det(255, 'hFFFFF4, 1000, 2000), 1'b0);
    send_det(mk_det(255, 'hFFFFF5, 1010, 2010), 1'b1);
    // Neighbors from different videos.
    send_det(mk_det(1, 10, 800, 800), 1'b0);
    send_det(mk_det(1, 11, 100, 100), 1'b0);
    send_det(mk_det(2, 12, 800, 800), 1'b1);
    // Neighbor distance equal to the gap limit.
    send_det(mk_det(4, 10, 800, 800), 1'b0);
    send_det(mk_det(4, 20, 100, 100), 1'b0);
    send_det(mk_det(4, 40, 800, 800), 1'b1);
    // Decreasing frame numbers still pass the gap test.
    send_det(mk_det(5, 500, 800, 800), 1'b0);
    send_det(mk_det(5, 300, 100, 100), 1'b0);
    send_det(mk_det(5, 100, 800, 800), 1'b1);
    // Field extremes; zero neighbors never make a stable axis.
    send_det(mk_det(0, 0, 0, 0), 1'b0);
    send_det(mk_det(255, 'hFFFFFF, COORD_MAX, COORD_MAX), 1'b0);
    send_det(mk_det(0, 0, 0, 0), 1'b1);
  endtask

  // Register extremes, masking of wide writes and writes to unused indexes.
  task automatic test_register_settings();
    wait_idle();
    write_register(tpsr_pkg::CFG_TOLERANCE, 10'd0);
    send_det(mk_det(6, 1, 1000, 1000), 1'b0);
    send_det(mk_det(6, 2, 4000, 4000), 1'b0);
    send_det(mk_det(6, 3, 1000, 1000), 1'b1);
    wait_idle();
    write_register(tpsr_pkg::CFG_TOLERANCE, 10'h3FF);
    write_register(tpsr_pkg::CFG_MAX_GAP, 10'd0);
    write_register(CFG_SPARE_LO, 10'h3FF);
    write_register(CFG_SPARE_HI, 10'h001);
    send_det(mk_det(7, 7, 1000, 1000), 1'b0);
    send_det(mk_det(7, 6, 4000, 4000), 1'b0);
    send_det(mk_det(7, 5, 1000, 1000), 1'b1);
    wait_idle();
    write_register(tpsr_pkg::CFG_TOLERANCE, 10'd100);
    write_register(tpsr_pkg::CFG_MAX_GAP, 10'h3FF);
    send_det(mk_det(8, 0, 1000, 1000), 1'b0);
    send_det(mk_det(8, 500, 4000, 4000), 1'b0);
    send_det(mk_det(8, 1022, 1000, 1000), 1'b1);
  endtask

  // One register setting followed by random streams with changing idle behavior.
  task automatic run_phase(input logic [CFG_DATA_W-1:0] tol, input logic [CFG_DATA_W-1:0] gap);
    int stop_at;
    int roll;
    wait_idle();
    write_register(tpsr_pkg::CFG_TOLERANCE, tol);
    write_register(tpsr_pkg::CFG_MAX_GAP, gap);
    stop_at = items_sent + PHASE_ITEMS;
    while (items_sent < stop_at) begin
      src_idle_max = ($urandom_range(3, 0) == 0) ? 0 : 15;
      snk_idle_max = ($urandom_range(3, 0) == 0) ? 0 : 15;
      roll = $urandom_range(99, 0);
      if (roll < 8) send_track_stream(1);
      else if (roll < 80) send_track_stream($urandom_range(12, 2));
      else send_track_stream($urandom_range(60, 13));
    end
  endtask

  task automatic test_random_streams();
    run_phase(10'd20, 10'd30);
    run_phase(10'd1, 10'd1);
    run_phase(10'd100, 10'd1023);
    run_phase(10'd35, 10'd3);
    run_phase(10'd8, 10'd600);
    run_phase(CFG_DATA_W'($urandom_range(100, 1)), CFG_DATA_W'($urandom_range(1023, 1)));
    run_phase(CFG_DATA_W'($urandom_range(100, 1)), CFG_DATA_W'($urandom_range(1023, 1)));
  endtask

  // Receiver holds off for a long stretch while beats keep coming, filling the block.
  task automatic test_output_backpressure();
    wait_idle();
    write_register(tpsr_pkg::CFG_TOLERANCE, 10'd20);
    write_register(tpsr_pkg::CFG_MAX_GAP, 10'd30);
    src_idle_max = 0;
    snk_idle_max = 0;
    hold_cycles  = 300;
    send_track_stream(40);
    src_idle_max = 15;
    snk_idle_max = 15;
    send_track_stream(20);
  endtask

  task automatic check_verdict();
    verdict_t want;
    if (pending_verdicts.size() == 0) begin
      note_failure($sformatf("unexpected result: vid %0d frame %0d x %0d y %0d drop %0b last %0b",
                             out_bus.out_video_index, out_bus.out_frame_number, out_bus.out_x,
                             out_bus.out_y, out_bus.drop, out_bus.last_out));
      return;
    end
    want = pending_verdicts.pop_front();
    if (out_bus.out_video_index !== want.det.video || out_bus.out_frame_number !== want.det.frame ||
        out_bus.out_x !== want.det.x || out_bus.out_y !== want.det.y ||
        out_bus.drop !== want.drop || out_bus.last_out !== want.is_last) begin
      note_failure($sformatf({"mismatch: expected vid %0d frame %0d x %0d y %0d drop %0b last %0b,",
                              " got vid %0d frame %0d x %0d y %0d drop %0b last %0b"},
                             want.det.video, want.det.frame, want.det.x, want.det.y, want.drop,
                             want.is_last, out_bus.out_video_index, out_bus.out_frame_number,
                             out_bus.out_x, out_bus.out_y, out_bus.drop, out_bus.last_out));
    end
  endtask

  // Result side: check each accepted beat, then stall at random or for a forced hold-off.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        check_verdict();
        stall_left = $urandom_range(snk_idle_max, 0);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Cycle limit on the whole run.
  initial begin : watchdog
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_verdicts.size());
    $display("status: fail");
    $finish;
  end

  initial begin : main
    rst_n               <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.video_index  <= '0;
    in_bus.frame_number <= '0;
    in_bus.x_position   <= '0;
    in_bus.y_position   <= '0;
    in_bus.end_of_list  <= 1'b0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= tpsr_pkg::CFG_TOLERANCE;
    cfg_bus.data        <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_defaults();
    test_register_settings();
    test_random_streams();
    test_output_backpressure();

    // Drain, then give the block time to show any stray result.
    wait_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_verdicts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/tpsr_pkg.sv
hdl/tpsr_det_if.sv
hdl/tpsr_res_if.sv
hdl/tpsr_cfg_if.sv
hdl/three_point_spike_rejector.sv
hdl/tpsr_checker.sv
verif/three_point_spike_rejector_tb.sv
